// File: rtl/core/irdla_pkg.sv
// Shared types, constants and calibration tables of the infrared distance averaging unit.
`default_nettype none

package irdla_pkg;

   // Channel and item geometry.
   localparam int CHANNELS      = 4;
   localparam int CH_W          = $clog2(CHANNELS);
   localparam int SAMPLE_BITS   = 8;
   localparam int HISTORY_DEPTH = 5;
   localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // Calibration polynomial: four Q8.24 terms, evaluated by Horner's rule in three steps.
   localparam int POLY_TERMS = 4;
   localparam int TERM_W     = $clog2(POLY_TERMS);
   localparam int MAC_STEPS  = POLY_TERMS - 1;
   localparam int STEP_W     = $clog2(MAC_STEPS);
   localparam int COEF_W     = 32;
   localparam int FRAC_BITS  = 24;
   localparam int ACC_W      = 22 + 2 * SAMPLE_BITS;
   localparam int MAC_PROD_W = ACC_W + SAMPLE_BITS + 1;
   localparam int SCALE_W    = ACC_W + 4;

   // History sample and averaging widths.
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = SAMPLE_W + $clog2(HISTORY_DEPTH);
   localparam int DIV_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int AVG_W     = SAMPLE_W + 1;

   // Configuration register widths.
   localparam int LIMIT_W     = 12;
   localparam int CODE_W      = 8;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAC_STEPS - 1);
   localparam logic [CH_W-1:0]   LAST_CHAN = CH_W'(CHANNELS - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

   localparam logic [SCALE_W-1:0] FRAC_MASK = SCALE_W'((64'd1 << FRAC_BITS) - 64'd1);

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   // Reciprocal of the history depth, exact for every reachable sum magnitude.
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

   // Register reset values.
   localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RESET = 12'sd230;
   localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RESET  = 12'sd40;
   localparam logic [CODE_W-1:0]         FAR_CODE_RESET   = 8'd245;
   localparam logic [CODE_W-1:0]         NEAR_CODE_RESET  = 8'd0;

   // Coefficients per channel, highest power first: c3, c2, c1, c0.
   localparam logic signed [COEF_W-1:0] COEF_TABLE [CHANNELS][POLY_TERMS] = '{
      '{-366, 109052, -12124894, 587470995},
      '{-466, 129185, -13347953, 601233346},
      '{-433, 129185, -13913345, 634490821},
      '{-392, 119118, -13186892, 621637796}
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIGH_LIMIT = 2'd0,
      CSR_LOW_LIMIT  = 2'd1,
      CSR_FAR_CODE   = 2'd2,
      CSR_NEAR_CODE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_IN_RANGE = 2'd0,
      STATUS_ABOVE    = 2'd1,
      STATUS_BELOW    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath, one set per cycle.
   typedef struct packed {
      logic              load_in;
      logic              mac_en;
      logic [STEP_W-1:0] mac_step;
      logic [CH_W-1:0]   mac_chan;
      logic              scale_en;
      logic              update_en;
      logic [CH_W-1:0]   update_chan;
      logic              divide_en;
      logic              classify_en;
      logic [CH_W-1:0]   classify_chan;
      logic              out_load;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/irdla_chan_if.sv
// Request and response channel interfaces of the infrared distance averaging unit.
`default_nettype none

interface irdla_req_if;
   logic                              valid;
   logic                              ready;
   logic [irdla_pkg::SAMPLE_BITS-1:0] right_front_raw;
   logic [irdla_pkg::SAMPLE_BITS-1:0] right_rear_raw;
   logic [irdla_pkg::SAMPLE_BITS-1:0] left_front_raw;
   logic [irdla_pkg::SAMPLE_BITS-1:0] left_rear_raw;

   modport source (
      output valid, right_front_raw, right_rear_raw, left_front_raw, left_rear_raw,
      input  ready
   );
   modport sink (
      input  valid, right_front_raw, right_rear_raw, left_front_raw, left_rear_raw,
      output ready
   );
endinterface

interface irdla_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [irdla_pkg::CODE_W-1:0] right_front_value;
   logic [irdla_pkg::CODE_W-1:0] right_rear_value;
   logic [irdla_pkg::CODE_W-1:0] left_front_value;
   logic [irdla_pkg::CODE_W-1:0] left_rear_value;
   logic [1:0]                   right_front_status;
   logic [1:0]                   right_rear_status;
   logic [1:0]                   left_front_status;
   logic [1:0]                   left_rear_status;

   modport source (
      output valid, right_front_value, right_rear_value, left_front_value, left_rear_value,
      output right_front_status, right_rear_status, left_front_status, left_rear_status,
      input  ready
   );
   modport sink (
      input  valid, right_front_value, right_rear_value, left_front_value, left_rear_value,
      input  right_front_status, right_rear_status, left_front_status, left_rear_status,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/irdla_datapath.sv
// Datapath: polynomial unit, history with running sums, divide by depth, classify, result register.
`default_nettype none

module irdla_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire irdla_pkg::cmd_type                   cmd,
   input  wire logic [irdla_pkg::SAMPLE_BITS-1:0]    raw_in [irdla_pkg::CHANNELS],
   input  wire logic                                 csr_we,
   input  wire logic [irdla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [irdla_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [irdla_pkg::CODE_W-1:0]              value_out [irdla_pkg::CHANNELS],
   output irdla_pkg::status_type                     status_out [irdla_pkg::CHANNELS]
);

   // Configuration registers.
   logic signed [irdla_pkg::LIMIT_W-1:0] high_limit_ff;
   logic signed [irdla_pkg::LIMIT_W-1:0] low_limit_ff;
   logic [irdla_pkg::CODE_W-1:0]         far_code_ff;
   logic [irdla_pkg::CODE_W-1:0]         near_code_ff;

   // Captured item and polynomial accumulator.
   logic [irdla_pkg::SAMPLE_BITS-1:0]     raw_ff [irdla_pkg::CHANNELS];
   logic signed [irdla_pkg::ACC_W-1:0]    acc_ff;
   logic signed [irdla_pkg::ACC_W-1:0]    acc_in;
   logic signed [irdla_pkg::ACC_W-1:0]    mul_a;
   logic signed [irdla_pkg::SAMPLE_BITS:0] mul_x;
   logic signed [irdla_pkg::MAC_PROD_W-1:0] mac_prod;
   logic [irdla_pkg::TERM_W-1:0]          coef_idx;

   // Scaling to tenths.
   logic signed [irdla_pkg::SCALE_W-1:0]  acc_ext;
   logic signed [irdla_pkg::SCALE_W-1:0]  scaled;
   logic signed [irdla_pkg::SCALE_W-1:0]  biased;
   logic signed [irdla_pkg::SCALE_W-1:0]  tenths;
   logic [irdla_pkg::SCALE_W-irdla_pkg::SAMPLE_W:0] tenths_top;
   logic signed [irdla_pkg::SAMPLE_W-1:0] sample_in;
   logic signed [irdla_pkg::SAMPLE_W-1:0] sample_ff;

   // History, running sums and slot index.
   logic signed [irdla_pkg::SAMPLE_W-1:0]
      hist_ff [irdla_pkg::HISTORY_DEPTH][irdla_pkg::CHANNELS];
   logic signed [irdla_pkg::SUM_W-1:0]    sum_ff [irdla_pkg::CHANNELS];
   logic signed [irdla_pkg::SUM_W-1:0]    upd_sum;
   logic signed [irdla_pkg::SAMPLE_W-1:0] old_sample;
   logic [irdla_pkg::SLOT_W-1:0]          slot_ff;
   logic signed [irdla_pkg::SUM_W-1:0]    div_sum_ff;

   // Divide by depth.
   logic                                  div_neg;
   logic [irdla_pkg::SUM_W-1:0]           div_mag;
   logic [irdla_pkg::PROD_W-1:0]          div_prod;
   logic [irdla_pkg::PROD_W-1:0]          prod_ff;
   logic                                  neg_ff;

   // Classification and result registers.
   logic [irdla_pkg::SAMPLE_W-1:0]        quot;
   logic [irdla_pkg::AVG_W-1:0]           avg_mag;
   logic signed [irdla_pkg::AVG_W-1:0]    avg;
   logic signed [irdla_pkg::AVG_W-1:0]    high_ext;
   logic signed [irdla_pkg::AVG_W-1:0]    low_ext;
   logic [irdla_pkg::CODE_W-1:0]          cls_value;
   irdla_pkg::status_type                 cls_status;
   logic [irdla_pkg::CODE_W-1:0]          stage_value_ff [irdla_pkg::CHANNELS];
   irdla_pkg::status_type                 stage_status_ff [irdla_pkg::CHANNELS];
   logic [irdla_pkg::CODE_W-1:0]          value_ff [irdla_pkg::CHANNELS];
   irdla_pkg::status_type                 status_ff [irdla_pkg::CHANNELS];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff <= irdla_pkg::HIGH_LIMIT_RESET;
         low_limit_ff  <= irdla_pkg::LOW_LIMIT_RESET;
         far_code_ff   <= irdla_pkg::FAR_CODE_RESET;
         near_code_ff  <= irdla_pkg::NEAR_CODE_RESET;
      end else if (csr_we) begin
         unique case (irdla_pkg::csr_index_type'(csr_index))
            irdla_pkg::CSR_HIGH_LIMIT: high_limit_ff <= csr_wdata;
            irdla_pkg::CSR_LOW_LIMIT:  low_limit_ff  <= csr_wdata;
            irdla_pkg::CSR_FAR_CODE:   far_code_ff   <= csr_wdata[irdla_pkg::CODE_W-1:0];
            irdla_pkg::CSR_NEAR_CODE:  near_code_ff  <= csr_wdata[irdla_pkg::CODE_W-1:0];
         endcase
      end
   end

   // Horner step: the first step multiplies the cubic coefficient, later ones the accumulator.
   always_comb begin
      coef_idx = irdla_pkg::TERM_W'(cmd.mac_step) + irdla_pkg::TERM_W'(1);
      mul_x    = $signed({1'b0, raw_ff[cmd.mac_chan]});
      mul_a    = (cmd.mac_step == '0)
               ? irdla_pkg::ACC_W'(irdla_pkg::COEF_TABLE[cmd.mac_chan][0]) : acc_ff;
      mac_prod = mul_a * mul_x;
      acc_in   = mac_prod[irdla_pkg::ACC_W-1:0]
               + irdla_pkg::ACC_W'(irdla_pkg::COEF_TABLE[cmd.mac_chan][coef_idx]);
   end

   // Times ten, shift out the fraction toward zero, then saturate to the sample width.
   always_comb begin
      acc_ext    = irdla_pkg::SCALE_W'(acc_ff);
      scaled     = (acc_ext <<< 3) + (acc_ext <<< 1);
      biased     = scaled + (scaled[irdla_pkg::SCALE_W-1] ? irdla_pkg::FRAC_MASK : '0);
      tenths     = biased >>> irdla_pkg::FRAC_BITS;
      tenths_top = tenths[irdla_pkg::SCALE_W-1:irdla_pkg::SAMPLE_W-1];
      if ((&tenths_top) || !(|tenths_top)) begin
         sample_in = tenths[irdla_pkg::SAMPLE_W-1:0];
      end else if (tenths[irdla_pkg::SCALE_W-1]) begin
         sample_in = irdla_pkg::SAMPLE_MIN;
      end else begin
         sample_in = irdla_pkg::SAMPLE_MAX;
      end
   end

   // The running sum drops the sample being replaced and adds the new one.
   always_comb begin
      old_sample = hist_ff[slot_ff][cmd.update_chan];
      upd_sum    = sum_ff[cmd.update_chan] - irdla_pkg::SUM_W'(old_sample)
                 + irdla_pkg::SUM_W'(sample_ff);
   end

   // Magnitude times the reciprocal of the depth.
   always_comb begin
      div_neg  = div_sum_ff[irdla_pkg::SUM_W-1];
      div_mag  = div_neg ? -div_sum_ff : div_sum_ff;
      div_prod = div_mag * irdla_pkg::DIV_RECIP;
   end

   // Signed average against the limits; the high limit is tested first.
   always_comb begin
      quot     = prod_ff[irdla_pkg::DIV_SHIFT +: irdla_pkg::SAMPLE_W];
      avg_mag  = {1'b0, quot};
      avg      = neg_ff ? -avg_mag : avg_mag;
      high_ext = irdla_pkg::AVG_W'(high_limit_ff);
      low_ext  = irdla_pkg::AVG_W'(low_limit_ff);
      if (avg > high_ext) begin
         cls_value  = far_code_ff;
         cls_status = irdla_pkg::STATUS_ABOVE;
      end else if (avg < low_ext) begin
         cls_value  = near_code_ff;
         cls_status = irdla_pkg::STATUS_BELOW;
      end else begin
         cls_status = irdla_pkg::STATUS_IN_RANGE;
         if (avg[irdla_pkg::AVG_W-1]) begin
            cls_value = '0;
         end else if (|avg[irdla_pkg::AVG_W-2:irdla_pkg::CODE_W]) begin
            cls_value = '1;
         end else begin
            cls_value = avg[irdla_pkg::CODE_W-1:0];
         end
      end
   end

   // History, running sums and slot index start cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < irdla_pkg::HISTORY_DEPTH; s++) begin
            for (int c = 0; c < irdla_pkg::CHANNELS; c++) begin
               hist_ff[s][c] <= '0;
            end
         end
         for (int c = 0; c < irdla_pkg::CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
         slot_ff <= '0;
      end else if (cmd.update_en) begin
         hist_ff[slot_ff][cmd.update_chan] <= sample_ff;
         sum_ff[cmd.update_chan]           <= upd_sum;
         if (cmd.update_chan == irdla_pkg::LAST_CHAN) begin
            slot_ff <= (slot_ff == irdla_pkg::LAST_SLOT)
                     ? '0 : slot_ff + irdla_pkg::SLOT_W'(1);
         end
      end
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_ff <= raw_in;
      end
      if (cmd.mac_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.scale_en) begin
         sample_ff <= sample_in;
      end
      if (cmd.update_en) begin
         div_sum_ff <= upd_sum;
      end
      if (cmd.divide_en) begin
         prod_ff <= div_prod;
         neg_ff  <= div_neg;
      end
      if (cmd.classify_en) begin
         stage_value_ff[cmd.classify_chan]  <= cls_value;
         stage_status_ff[cmd.classify_chan] <= cls_status;
      end
      if (cmd.out_load) begin
         value_ff  <= stage_value_ff;
         status_ff <= stage_status_ff;
      end
   end

   assign value_out  = value_ff;
   assign status_out = status_ff;

endmodule

`default_nettype wire

// File: rtl/core/irdla_ctrl.sv
// Controller: sequences the polynomial steps per channel, tracks the tail stages, owns the handshakes.
`default_nettype none

module irdla_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output irdla_pkg::cmd_type cmd
);

   irdla_pkg::state_type             state_ff;
   irdla_pkg::state_type             state_in;
   logic [irdla_pkg::STEP_W-1:0]     step_ff;
   logic [irdla_pkg::STEP_W-1:0]     step_in;
   logic [irdla_pkg::CH_W-1:0]       chan_ff;
   logic [irdla_pkg::CH_W-1:0]       chan_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;

   // Tail stage tags: scale, update, divide, classify.
   logic                             scl_vld_ff;
   logic [irdla_pkg::CH_W-1:0]       scl_ch_ff;
   logic                             upd_vld_ff;
   logic [irdla_pkg::CH_W-1:0]       upd_ch_ff;
   logic                             div_vld_ff;
   logic [irdla_pkg::CH_W-1:0]       div_ch_ff;
   logic                             cls_vld_ff;
   logic [irdla_pkg::CH_W-1:0]       cls_ch_ff;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irdla_pkg::ST_IDLE;
         step_ff      <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A channel enters the tail after its last polynomial step and moves one stage a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scl_vld_ff <= 1'b0;
         upd_vld_ff <= 1'b0;
         div_vld_ff <= 1'b0;
         cls_vld_ff <= 1'b0;
         scl_ch_ff  <= '0;
         upd_ch_ff  <= '0;
         div_ch_ff  <= '0;
         cls_ch_ff  <= '0;
      end else begin
         scl_vld_ff <= cmd.mac_en && (step_ff == irdla_pkg::LAST_STEP);
         scl_ch_ff  <= chan_ff;
         upd_vld_ff <= scl_vld_ff;
         upd_ch_ff  <= scl_ch_ff;
         div_vld_ff <= upd_vld_ff;
         div_ch_ff  <= upd_ch_ff;
         cls_vld_ff <= div_vld_ff;
         cls_ch_ff  <= div_ch_ff;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      chan_in   = chan_ff;
      req_ready = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         irdla_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               step_in     = '0;
               chan_in     = '0;
               state_in    = irdla_pkg::ST_MAC;
            end
         end
         irdla_pkg::ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (step_ff == irdla_pkg::LAST_STEP) begin
               step_in = '0;
               chan_in = chan_ff + irdla_pkg::CH_W'(1);
               if (chan_ff == irdla_pkg::LAST_CHAN) begin
                  state_in = irdla_pkg::ST_DRAIN;
               end
            end else begin
               step_in = step_ff + irdla_pkg::STEP_W'(1);
            end
         end
         irdla_pkg::ST_DRAIN: begin
            if (cls_vld_ff && (cls_ch_ff == irdla_pkg::LAST_CHAN)) begin
               state_in = irdla_pkg::ST_HOLD;
            end
         end
         irdla_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = irdla_pkg::ST_IDLE;
            end
         end
      endcase

      cmd.mac_step      = step_ff;
      cmd.mac_chan      = chan_ff;
      cmd.scale_en      = scl_vld_ff;
      cmd.update_en     = upd_vld_ff;
      cmd.update_chan   = upd_ch_ff;
      cmd.divide_en     = div_vld_ff;
      cmd.classify_en   = cls_vld_ff;
      cmd.classify_chan = cls_ch_ff;

      // The result register fills on a load and empties when taken.
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new item is never taken while a channel is still in the tail.
   a_accept_tail_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !(scl_vld_ff || upd_vld_ff || div_vld_ff || cls_vld_ff))
      else $error("item accepted while the tail stages are busy");

   // Channels enter the tail spaced by their polynomial steps, so at most two stages are busy.
   a_tail_spacing: assert property (@(posedge clock) disable iff (reset)
      $countones({scl_vld_ff, upd_vld_ff, div_vld_ff, cls_vld_ff}) <= 2)
      else $error("tail stages overlap more than expected");

   // Classifying the last channel ends the drain.
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (cls_vld_ff && (cls_ch_ff == irdla_pkg::LAST_CHAN)) |=> (state_ff == irdla_pkg::ST_HOLD))
      else $error("last channel classified without moving to hold");

   // A fresh result appears only from the hold state.
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == irdla_pkg::ST_HOLD))
      else $error("result raised outside the hold state");

endmodule

`default_nettype wire

// File: rtl/core/ir_distance_linearize_average_unit.sv
// Top level of the four-channel infrared distance linearizer with moving average.
`default_nettype none

// One item holds one raw reading from each of the four sensors and produces one result
// item with a value and a status per sensor. Items are processed one at a time: the
// input is ready again in the cycle after the result register is loaded, so a new item
// is not accepted before the last one is through. Each item passes through the shared
// multiply-accumulate unit, which evaluates each channel's cubic in three Horner steps,
// followed by four tail stages for the last channel (scale to tenths, history and
// running-sum update, divide by the depth, classify), and then the result register is
// loaded. The result register holds a finished item until it is taken, while the next
// item is accepted and worked on. The history and running sums are cleared by reset in
// the same cycle; there is no clearing pass. Configuration writes take effect at once and
// are meant to be made while the unit is idle.
module ir_distance_linearize_average_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   irdla_req_if.sink                              req_ch,
   irdla_rsp_if.source                            rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [irdla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [irdla_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   irdla_pkg::cmd_type                cmd;
   logic [irdla_pkg::SAMPLE_BITS-1:0] raw [irdla_pkg::CHANNELS];
   logic [irdla_pkg::CODE_W-1:0]      value [irdla_pkg::CHANNELS];
   irdla_pkg::status_type             status [irdla_pkg::CHANNELS];

   // Channel order: right front, right rear, left front, left rear.
   assign raw[0] = req_ch.right_front_raw;
   assign raw[1] = req_ch.right_rear_raw;
   assign raw[2] = req_ch.left_front_raw;
   assign raw[3] = req_ch.left_rear_raw;

   irdla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   irdla_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .raw_in     (raw),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .value_out  (value),
      .status_out (status)
   );

   // Result fields.
   assign rsp_ch.right_front_value  = value[0];
   assign rsp_ch.right_rear_value   = value[1];
   assign rsp_ch.left_front_value   = value[2];
   assign rsp_ch.left_rear_value    = value[3];
   assign rsp_ch.right_front_status = status[0];
   assign rsp_ch.right_rear_status  = status[1];
   assign rsp_ch.left_front_status  = status[2];
   assign rsp_ch.left_rear_status   = status[3];

endmodule

`default_nettype wire

// File: bench/irdla_report_checker.sv
// Checker for the infrared distance averaging unit: predicts each result item and compares it.
`default_nettype none

module irdla_report_checker
   import irdla_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   irdla_req_if                        req_ch,
   irdla_rsp_if                        rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          reports_pending
);

   localparam int SENSORS = 4;
   localparam int DEPTH   = 5;

   // Calibration terms per sensor in Q8.24, highest power first.
   localparam longint CAL_Q24 [SENSORS][4] = '{
      '{-64'sd366, 64'sd109052, -64'sd12124894, 64'sd587470995},
      '{-64'sd466, 64'sd129185, -64'sd13347953, 64'sd601233346},
      '{-64'sd433, 64'sd129185, -64'sd13913345, 64'sd634490821},
      '{-64'sd392, 64'sd119118, -64'sd13186892, 64'sd621637796}
   };
   localparam longint Q24_ONE = 64'sd16777216;

   // Values the limit and code registers take at reset.
   localparam int               HIGH_AT_RESET = 230;
   localparam int               LOW_AT_RESET  = 40;
   localparam logic [CODE_W-1:0] FAR_AT_RESET  = 8'd245;
   localparam logic [CODE_W-1:0] NEAR_AT_RESET = 8'd0;

   typedef struct packed {
      logic [SENSORS-1:0][CODE_W-1:0] value;
      status_type [SENSORS-1:0]       status;
   } sensor_report_type;

   shortint             distance_tenths [SENSORS][DEPTH];
   int                  write_slot;
   int                  high_limit_q;
   int                  low_limit_q;
   logic [CODE_W-1:0]   far_code_q;
   logic [CODE_W-1:0]   near_code_q;
   sensor_report_type   pending_reports [$];
   string               sensor_label [SENSORS] = '{"right_front", "right_rear",
                                                   "left_front", "left_rear"};

   // Print one failure line and count it.
   task automatic note_failure(input string msg);
      $display("%0t checker: %s", $time, msg);
      mismatch_count++;
   endtask

   // Cubic calibration of one raw reading, truncated toward zero and saturated to 16 bits.
   function automatic shortint tenths_of_cm(input int sensor, input logic [SAMPLE_BITS-1:0] raw);
      longint x;
      longint poly;
      longint tenths;
      x      = longint'(raw);
      poly   = CAL_Q24[sensor][0] * x * x * x + CAL_Q24[sensor][1] * x * x
             + CAL_Q24[sensor][2] * x + CAL_Q24[sensor][3];
      tenths = (poly * 10) / Q24_ONE;
      if (tenths > 32767) begin
         tenths = 32767;
      end else if (tenths < -32768) begin
         tenths = -32768;
      end
      return shortint'(tenths);
   endfunction

   // Store one item's distances in the shared slot, then average and classify each sensor.
   function automatic sensor_report_type advance_history(
      input logic [SENSORS-1:0][SAMPLE_BITS-1:0] raw
   );
      sensor_report_type rep;
      int slot;
      int sum;
      int avg;
      slot = (write_slot < DEPTH) ? write_slot : 0;
      for (int s = 0; s < SENSORS; s++) begin
         distance_tenths[s][slot] = tenths_of_cm(s, raw[s]);
      end
      write_slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
      for (int s = 0; s < SENSORS; s++) begin
         sum = 0;
         for (int k = 0; k < DEPTH; k++) begin
            sum += int'(distance_tenths[s][k]);
         end
         avg = sum / DEPTH;
         // The high limit wins when both limits would apply.
         if (avg > high_limit_q) begin
            rep.value[s]  = far_code_q;
            rep.status[s] = STATUS_ABOVE;
         end else if (avg < low_limit_q) begin
            rep.value[s]  = near_code_q;
            rep.status[s] = STATUS_BELOW;
         end else begin
            rep.value[s]  = (avg < 0) ? 8'd0 : (avg > 255) ? 8'd255 : CODE_W'(avg);
            rep.status[s] = STATUS_IN_RANGE;
         end
      end
      return rep;
   endfunction

   // Track register writes, predict on each accepted input item, check each result item.
   always @(posedge clock) begin : watch
      sensor_report_type                   want;
      logic [SENSORS-1:0][SAMPLE_BITS-1:0] raw;
      logic [SENSORS-1:0][CODE_W-1:0]      got_value;
      logic [SENSORS-1:0][1:0]             got_status;
      if (reset) begin
         for (int s = 0; s < SENSORS; s++) begin
            for (int k = 0; k < DEPTH; k++) begin
               distance_tenths[s][k] = 16'sd0;
            end
         end
         write_slot     = 0;
         high_limit_q   = HIGH_AT_RESET;
         low_limit_q    = LOW_AT_RESET;
         far_code_q     = FAR_AT_RESET;
         near_code_q    = NEAR_AT_RESET;
         mismatch_count = 0;
         pending_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HIGH_LIMIT: high_limit_q = int'($signed(csr_wdata[LIMIT_W-1:0]));
               CSR_LOW_LIMIT:  low_limit_q  = int'($signed(csr_wdata[LIMIT_W-1:0]));
               CSR_FAR_CODE:   far_code_q   = csr_wdata[CODE_W-1:0];
               CSR_NEAR_CODE:  near_code_q  = csr_wdata[CODE_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            raw = {req_ch.left_rear_raw, req_ch.left_front_raw,
                   req_ch.right_rear_raw, req_ch.right_front_raw};
            pending_reports.push_back(advance_history(raw));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_reports.size() == 0) begin
               note_failure("result item arrived with none expected");
            end else begin
               want       = pending_reports.pop_front();
               got_value  = {rsp_ch.left_rear_value, rsp_ch.left_front_value,
                             rsp_ch.right_rear_value, rsp_ch.right_front_value};
               got_status = {rsp_ch.left_rear_status, rsp_ch.left_front_status,
                             rsp_ch.right_rear_status, rsp_ch.right_front_status};
               for (int s = 0; s < SENSORS; s++) begin
                  if (got_value[s] !== want.value[s]) begin
                     note_failure($sformatf("%s_value got %0d expected %0d",
                                            sensor_label[s], got_value[s], want.value[s]));
                  end
                  if (got_status[s] !== want.status[s]) begin
                     note_failure($sformatf("%s_status got %0d expected %0d",
                                            sensor_label[s], got_status[s], want.status[s]));
                  end
               end
            end
         end
      end
      reports_pending = pending_reports.size();
   end

endmodule

`default_nettype wire

// File: bench/ir_distance_linearize_average_unit_tb.sv
// Testbench top of the infrared distance averaging unit: clock, reset, stimulus and verdict.
`default_nettype none

module ir_distance_linearize_average_unit_tb;
   import irdla_pkg::*;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int SETTLE_CYCLES     = 24;
   localparam int ITEMS_PER_SETTING = 50;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatch_count;
   int                     reports_pending;
   int                     send_idle_pct;
   int                     take_idle_pct;
   int                     cycles;
   logic [SAMPLE_BITS-1:0] last_raw [4];

   irdla_req_if req_if ();
   irdla_rsp_if rsp_if ();

   ir_distance_linearize_average_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   irdla_report_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_if),
      .rsp_ch          (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The result side takes items at random, at the rate the current phase allows.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Run limit: a hung handshake ends the run as a failure.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ir_distance_linearize_average_unit_tb NOT OK");
      $finish;
   end

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_item(input logic [SAMPLE_BITS-1:0] rf, rr, lf, lr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.right_front_raw <= rf;
      req_if.right_rear_raw  <= rr;
      req_if.left_front_raw  <= lf;
      req_if.left_rear_raw   <= lr;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted result item has been taken.
   task automatic drain_reports();
      req_if.valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four registers back to back; the upper data bits of the codes are junk.
   task automatic write_settings(input logic [LIMIT_W-1:0] high, low,
                                 input logic [CODE_W-1:0] far, near);
      csr_we    <= 1'b1;
      csr_index <= CSR_HIGH_LIMIT;
      csr_wdata <= high;
      @(negedge clock);
      csr_index <= CSR_LOW_LIMIT;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_FAR_CODE;
      csr_wdata <= {4'($urandom), far};
      @(negedge clock);
      csr_index <= CSR_NEAR_CODE;
      csr_wdata <= {4'($urandom), near};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Readings mix the extremes, slow drift around the last value and uniform noise.
   function automatic logic [SAMPLE_BITS-1:0] next_raw(input logic [SAMPLE_BITS-1:0] prev);
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2, 3, 4: return prev + 8'($urandom_range(6)) - 8'd3;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Random items, with one full drain partway through.
   task automatic send_random(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            drain_reports();
         end
         for (int s = 0; s < 4; s++) begin
            last_raw[s] = next_raw(last_raw[s]);
         end
         send_item(last_raw[0], last_raw[1], last_raw[2], last_raw[3]);
      end
   endtask

   initial begin : stimulus
      int hi;
      int lo;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_HIGH_LIMIT;
      csr_wdata              = '0;
      req_if.valid           = 1'b0;
      req_if.right_front_raw = '0;
      req_if.right_rear_raw  = '0;
      req_if.left_front_raw  = '0;
      req_if.left_rear_raw   = '0;
      send_idle_pct          = 31;
      take_idle_pct          = 76;
      for (int s = 0; s < 4; s++) begin
         last_raw[s] = 8'd64;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items under the reset settings: zero history first, then full extremes.
      send_item(8'h00, 8'h00, 8'h00, 8'h00);
      send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(8'h55, 8'h55, 8'h55, 8'h55);
      send_item(8'hAA, 8'hAA, 8'hAA, 8'hAA);
      send_item(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_item(8'hFF, 8'h00, 8'hFF, 8'h00);
      // A full history of zero readings drives every average above the high limit.
      repeat (5) send_item(8'h00, 8'h00, 8'h00, 8'h00);
      // A full history of full-scale readings drives every average below the low limit.
      repeat (5) send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(8'h01, 8'h02, 8'h04, 8'h08);
      send_item(8'h10, 8'h20, 8'h40, 8'h80);
      // Mid-range readings settle into the in-range band.
      repeat (3) send_item(8'd40, 8'd60, 8'd80, 8'd20);
      drain_reports();

      // Three idling regimes, each through four register settings.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               take_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               take_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         for (int setting = 0; setting < 4; setting++) begin
            case (setting)
               // Widest limits: every average is in range and the value saturates.
               0: write_settings(12'h7FF, 12'h800, 8'($urandom), 8'($urandom));
               // Crossed limits: the high limit is tested first, so far code wins.
               1: write_settings(12'h800, 12'h7FF, (phase == 0) ? 8'h00 : 8'hFF, 8'($urandom));
               // Both limits at the top: every average is below the low limit.
               2: write_settings(12'h7FF, 12'h7FF, 8'($urandom), (phase == 0) ? 8'hFF : 8'h00);
               default: begin
                  hi = int'($urandom_range(600)) - 300;
                  lo = hi - int'($urandom_range(300));
                  write_settings(LIMIT_W'(hi), LIMIT_W'(lo), 8'($urandom), 8'($urandom));
               end
            endcase
            send_random(ITEMS_PER_SETTING, $urandom_range(10, 40));
            drain_reports();
         end
      end

      if (mismatch_count == 0) begin
         $display("ir_distance_linearize_average_unit_tb OK");
      end else begin
         $display("ir_distance_linearize_average_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/irdla_pkg.sv
rtl/core/irdla_chan_if.sv
rtl/core/irdla_datapath.sv
rtl/core/irdla_ctrl.sv
rtl/core/ir_distance_linearize_average_unit.sv
bench/irdla_report_checker.sv
bench/ir_distance_linearize_average_unit_tb.sv
